FILE: sv/vtpd_pkg.sv
// Package for the vertex transform and perspective divide block.
// Holds widths, reset values of the matrix rows and the shared item types.
// No dependencies.
`default_nettype none

package vtpd_pkg;

  localparam int DIM        = 4;
  localparam int COORD_W    = 32;
  localparam int COEF_W     = 16;
  localparam int ROW_W      = DIM * COEF_W;
  localparam int PROD_W     = COORD_W + COEF_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int FRAC_SHIFT = 8;
  localparam int DIV_STEPS  = COORD_W + 16;
  localparam int CFG_IDX_W  = 8;
  localparam int QUEUE_DEPTH = 4;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ROW_ZERO  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_ONE   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_TWO   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_THREE = 8'd3;

  // Identity matrix at reset
  localparam logic [ROW_W-1:0] ROW_ZERO_RST  = 64'h0000_0000_0000_0100;
  localparam logic [ROW_W-1:0] ROW_ONE_RST   = 64'h0000_0000_0100_0000;
  localparam logic [ROW_W-1:0] ROW_TWO_RST   = 64'h0000_0100_0000_0000;
  localparam logic [ROW_W-1:0] ROW_THREE_RST = 64'h0100_0000_0000_0000;

  localparam logic [COORD_W-1:0] I32_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] I32_MIN = 32'h8000_0000;

  // Transformed vertex as queued between front and back
  typedef struct packed {
    logic [COORD_W-1:0] tx;
    logic [COORD_W-1:0] ty;
    logic [COORD_W-1:0] tz;
    logic [COORD_W-1:0] tw;
    logic               dz;
    logic               ovf;
  } vtx_item_t;

  // One step of the three-lane restoring divider
  typedef struct packed {
    logic [COORD_W-1:0]             d;
    logic [2:0]                     neg;
    logic [2:0]                     n_neg;
    logic [2:0]                     n_zero;
    logic [2:0][COORD_W-1:0]        rem;
    logic [2:0][DIV_STEPS-1:0]      nq;
    logic                           dz;
    logic                           ovf;
    logic [COORD_W-1:0]             w;
  } div_stage_t;

endpackage

`default_nettype wire

FILE: sv/vtpd_front.sv
// Front part: matrix row registers, 4x4 multiply and rounding/saturation.
// Two register stages; depends on vtpd_pkg.
`default_nettype none

module vtpd_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [vtpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [vtpd_pkg::ROW_W-1:0]     cfg_data,
  input  wire logic                          in_take,
  input  wire logic [4*vtpd_pkg::COORD_W-1:0] in_data,
  output logic [1:0]                         inflight,
  output logic                               push,
  output vtpd_pkg::vtx_item_t                push_item
);
  import vtpd_pkg::*;

  logic [ROW_W-1:0]               row_r [DIM];
  logic signed [PROD_W-1:0]       prod_r [DIM][DIM];
  logic signed [PROD_W-1:0]       prod_nxt [DIM][DIM];
  logic                           v1_r, v2_r;
  vtx_item_t                      item_r, item_nxt;

  // Configuration writes; indexes beyond the rows are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= ROW_ZERO_RST;
      row_r[1] <= ROW_ONE_RST;
      row_r[2] <= ROW_TWO_RST;
      row_r[3] <= ROW_THREE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_ZERO:  row_r[0] <= cfg_data;
        REG_ROW_ONE:   row_r[1] <= cfg_data;
        REG_ROW_TWO:   row_r[2] <= cfg_data;
        REG_ROW_THREE: row_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: sixteen 16x32 products
  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        prod_nxt[r][c] = $signed(row_r[r][c*COEF_W +: COEF_W]) *
                         $signed(in_data[c*COORD_W +: COORD_W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Stage 2: row sums, round half up, saturate
  always_comb begin
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   shd;
    logic [COORD_W-1:0]        t [DIM];
    logic                      ovf;
    ovf = 1'b0;
    for (int r = 0; r < DIM; r++) begin
      acc = ACC_W'(prod_r[r][0]) + ACC_W'(prod_r[r][1]) +
            ACC_W'(prod_r[r][2]) + ACC_W'(prod_r[r][3]) +
            ACC_W'(128);
      shd = acc >>> FRAC_SHIFT;
      if (shd > $signed({{(ACC_W-COORD_W){1'b0}}, I32_MAX})) begin
        t[r] = I32_MAX;
        ovf  = 1'b1;
      end else if (shd < $signed({{(ACC_W-COORD_W){1'b1}}, I32_MIN})) begin
        t[r] = I32_MIN;
        ovf  = 1'b1;
      end else begin
        t[r] = shd[COORD_W-1:0];
      end
    end
    item_nxt.tx  = t[0];
    item_nxt.ty  = t[1];
    item_nxt.tz  = t[2];
    item_nxt.tw  = t[3];
    item_nxt.dz  = (t[3] == '0);
    item_nxt.ovf = ovf;
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_take;
      v2_r <= v1_r;
    end
  end

  assign inflight  = {1'b0, v1_r} + {1'b0, v2_r};
  assign push      = v2_r;
  assign push_item = item_r;

endmodule

`default_nettype wire

FILE: sv/vtpd_queue.sv
// Short queue of transformed vertices between front and back.
// Registers only; depends on vtpd_pkg.
`default_nettype none

module vtpd_queue #(
  parameter int DEPTH = vtpd_pkg::QUEUE_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire vtpd_pkg::vtx_item_t    push_item,
  input  wire logic                   pop,
  output logic                        head_valid,
  output vtpd_pkg::vtx_item_t         head_item,
  output logic [$clog2(DEPTH+1)-1:0]  count
);
  import vtpd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  vtx_item_t         mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_r, rd_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_pop;

  assign do_pop = pop && (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_item;
  end

  // Pointers wrap at DEPTH
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PTR_W'(DEPTH-1)) ? '0 : wr_r + 1'b1;
      if (do_pop) rd_r <= (rd_r == PTR_W'(DEPTH-1)) ? '0 : rd_r + 1'b1;
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(do_pop);
    end
  end

  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rd_r];
  assign count      = cnt_r;

endmodule

`default_nettype wire

FILE: sv/vtpd_back.sv
// Back part: three-lane pipelined restoring divider and output register.
// One quotient bit per stage; depends on vtpd_pkg.
`default_nettype none

module vtpd_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           head_valid,
  input  wire vtpd_pkg::vtx_item_t            head_item,
  output logic                                pop,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [4*vtpd_pkg::COORD_W-1:0]      out_tdata,
  output logic [1:0]                          out_tuser
);
  import vtpd_pkg::*;

  div_stage_t  stg_r   [DIV_STEPS+1];
  div_stage_t  stg_nxt [DIV_STEPS+1];
  logic        vld_r   [DIV_STEPS+1];
  logic        en;
  logic        out_valid_r;
  logic [4*COORD_W-1:0] data_r, data_nxt;
  logic [1:0]  user_r, user_nxt;

  // Whole back pipeline moves when the output word can move
  assign en  = !out_valid_r || out_tready;
  assign pop = en && head_valid;

  // Prep stage: magnitudes and signs
  always_comb begin
    logic [COORD_W-1:0] n [3];
    logic               dn;
    n[0] = head_item.tx;
    n[1] = head_item.ty;
    n[2] = head_item.tz;
    dn   = head_item.tw[COORD_W-1];
    stg_nxt[0].d   = dn ? (~head_item.tw + 1'b1) : head_item.tw;
    stg_nxt[0].dz  = head_item.dz;
    stg_nxt[0].ovf = head_item.ovf;
    stg_nxt[0].w   = head_item.tw;
    for (int l = 0; l < 3; l++) begin
      stg_nxt[0].n_neg[l]  = n[l][COORD_W-1];
      stg_nxt[0].n_zero[l] = (n[l] == '0);
      stg_nxt[0].neg[l]    = n[l][COORD_W-1] ^ dn;
      stg_nxt[0].rem[l]    = '0;
      stg_nxt[0].nq[l]     = {(n[l][COORD_W-1] ? (~n[l] + 1'b1) : n[l]), 16'h0000};
    end
  end

  // Divider steps: shift one dividend bit in, subtract when it fits
  for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
    always_comb begin
      logic [COORD_W:0] sh;
      logic             qb;
      stg_nxt[s] = stg_r[s-1];
      for (int l = 0; l < 3; l++) begin
        sh = {stg_r[s-1].rem[l], stg_r[s-1].nq[l][DIV_STEPS-1]};
        qb = (sh >= {1'b0, stg_r[s-1].d});
        stg_nxt[s].rem[l] = qb ? COORD_W'(sh - {1'b0, stg_r[s-1].d}) : sh[COORD_W-1:0];
        stg_nxt[s].nq[l]  = {stg_r[s-1].nq[l][DIV_STEPS-2:0], qb};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) stg_r <= stg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= DIV_STEPS; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= head_valid;
      for (int s = 1; s <= DIV_STEPS; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  // Sign, saturation and zero-divisor handling
  always_comb begin
    logic [COORD_W-1:0] qv [3];
    logic [DIV_STEPS-1:0] q;
    logic               ovf;
    div_stage_t         f;
    f   = stg_r[DIV_STEPS];
    ovf = f.ovf;
    for (int l = 0; l < 3; l++) begin
      q = f.nq[l];
      if (f.dz) begin
        qv[l] = f.n_zero[l] ? '0 : (f.n_neg[l] ? I32_MIN : I32_MAX);
      end else if (!f.neg[l]) begin
        if (q > DIV_STEPS'(I32_MAX)) begin
          qv[l] = I32_MAX;
          ovf   = 1'b1;
        end else begin
          qv[l] = q[COORD_W-1:0];
        end
      end else begin
        if (q > DIV_STEPS'(I32_MIN)) begin
          qv[l] = I32_MIN;
          ovf   = 1'b1;
        end else begin
          qv[l] = ~q[COORD_W-1:0] + 1'b1;
        end
      end
    end
    data_nxt = {f.w, qv[2], qv[1], qv[0]};
    user_nxt = {ovf, f.dz};
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
      user_r <= user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

endmodule

`default_nettype wire

FILE: sv/vertex_transform_perspective_divide.sv
// Homogeneous 4x4 vertex transform with perspective divide, fixed point.
// Input stream: in_tdata carries x, y, z, w (signed Q16.16, x lowest).
// Output stream: out_tdata carries x/w, y/w, z/w and w (Q16.16, saturated);
// out_tuser carries div_by_zero (bit 0) and overflow (bit 1).
// Config port: cfg_index 0..3 selects a matrix row (four Q8.8 entries,
// column j at bits 16j); other indexes are ignored. Always ready.
// Throughput: one word per cycle unless out_tready or a full queue holds it. A word
// passes through two multiply/sum stages, the queue registers, a prep stage,
// 48 divider steps (one quotient bit each) and the output register.
// The front accepts a word whenever the queue has room for every word still
// in flight, so it does not see out_tready directly. A stalled receiver
// freezes the divider pipeline; the queue then fills and in_tready drops.
// Reset (rst_n low, synchronous) empties all stages and the queue and loads
// the identity matrix.
// Depends on vtpd_pkg, vtpd_front, vtpd_queue, vtpd_back.
`default_nettype none

module vertex_transform_perspective_divide #(
  parameter int QDEPTH = vtpd_pkg::QUEUE_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [vtpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [vtpd_pkg::ROW_W-1:0]     cfg_data,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // in_x, in_y, in_z, in_w
  input  wire logic [4*vtpd_pkg::COORD_W-1:0] in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // out_x, out_y, out_z, out_w
  output logic [4*vtpd_pkg::COORD_W-1:0]      out_tdata,
  // div_by_zero, overflow
  output logic [1:0]                          out_tuser
);
  import vtpd_pkg::*;

  localparam int CNT_W = $clog2(QDEPTH+1);

  logic             in_take;
  logic [1:0]       inflight;
  logic             push, pop, head_valid;
  vtx_item_t        push_item, head_item;
  logic [CNT_W-1:0] q_count;

  assign cfg_ready = 1'b1;
  // Credit check: queue entries plus front stages must fit the queue
  assign in_tready = ((CNT_W+2)'(q_count) + (CNT_W+2)'(inflight)) < (CNT_W+2)'(QDEPTH);
  assign in_take   = in_tvalid && in_tready;

  vtpd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_take   (in_take),
    .in_data   (in_tdata),
    .inflight  (inflight),
    .push      (push),
    .push_item (push_item)
  );

  vtpd_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item),
    .count      (q_count)
  );

  vtpd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
